// ----- rtl/text_mode_console_writer_assert.svh -----
// Assertion macros shared by the console writer checker.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef TEXT_MODE_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_MODE_CONSOLE_WRITER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define TMCW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle.
`define TMCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Implication with a delayed consequent.
`define TMCW_ASSERT_DLY2(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

// ----- rtl/tmcw_pkg.sv -----
// Shared types and constants of the text mode console writer.
// No dependencies; used by every other file of the block but the assertion header.
package tmcw_pkg;

  // Default screen geometry.
  localparam int unsigned COLUMNS_DEF  = 80;
  localparam int unsigned ROWS_DEF     = 25;
  localparam int unsigned TAB_STOP_DEF = 8;

  // Fixed field widths.
  localparam int unsigned CellW  = 16;
  localparam int unsigned CharW  = 8;
  localparam int unsigned IndexW = 11;
  localparam int unsigned ColW   = 7;
  localparam int unsigned RowW   = 5;

  // Cell contents.
  localparam logic [CharW-1:0] BLANK_CHAR       = 8'd32;
  localparam logic [CharW-1:0] FIRST_PRINTABLE  = 8'd32;
  localparam logic [CharW-1:0] PAST_PRINTABLE   = 8'd127;
  localparam logic [CharW-1:0] CLEAR_COLOR      = 8'd15;
  localparam logic [CharW-1:0] TEXT_COLOR_RESET = 8'd15;
  localparam logic [CellW-1:0] CLEAR_CELL       = {CLEAR_COLOR, BLANK_CHAR};

  // Control characters.
  localparam logic [CharW-1:0] CHAR_BS  = 8'd8;
  localparam logic [CharW-1:0] CHAR_TAB = 8'd9;
  localparam logic [CharW-1:0] CHAR_LF  = 8'd10;
  localparam logic [CharW-1:0] CHAR_CR  = 8'd13;

  // Actions of one input transaction.
  typedef enum logic [1:0] {
    ACT_PUT   = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_SET   = 2'd3
  } action_e;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_READ   = 6'b000100,
    ST_TAB    = 6'b001000,
    ST_SCROLL = 6'b010000,
    ST_FILL   = 6'b100000
  } state_e;

endpackage

// ----- rtl/tmcw_screen.sv -----
// Screen cell memory: one write port and one registered read port.
// Depends on tmcw_pkg for the cell width.
module tmcw_screen #(
  parameter int unsigned DEPTH = 2000,
  parameter int unsigned AW    = 11
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [tmcw_pkg::CellW-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [tmcw_pkg::CellW-1:0] rdata_o
);

  logic [tmcw_pkg::CellW-1:0] mem_q [DEPTH];
  logic [tmcw_pkg::CellW-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/tmcw_seq.sv -----
// Sequencer of the console writer: cursor, color register, sweeps and results.
// Depends on tmcw_pkg; drives the ports of tmcw_screen.
module tmcw_seq #(
  parameter int unsigned COLUMNS  = tmcw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS     = tmcw_pkg::ROWS_DEF,
  parameter int unsigned TAB_STOP = tmcw_pkg::TAB_STOP_DEF,
  parameter int unsigned AW       = 11
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Command channel
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  action_i,
  input  logic [tmcw_pkg::CharW-1:0]  char_code_i,
  input  logic [tmcw_pkg::IndexW-1:0] cell_index_i,
  input  logic [tmcw_pkg::ColW-1:0]   new_col_i,
  input  logic [tmcw_pkg::RowW-1:0]   new_row_i,
  // Result channel
  output logic                        done_o,
  output logic [tmcw_pkg::CellW-1:0]  cell_value_o,
  output logic [tmcw_pkg::IndexW-1:0] cursor_position_o,
  output logic [tmcw_pkg::ColW-1:0]   cursor_col_o,
  output logic [tmcw_pkg::RowW-1:0]   cursor_row_o,
  // Configuration channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [tmcw_pkg::CharW-1:0]  cfg_data_i,
  // Memory ports
  output logic                        we_o,
  output logic [AW-1:0]               waddr_o,
  output logic [tmcw_pkg::CellW-1:0]  wdata_o,
  output logic                        re_o,
  output logic [AW-1:0]               raddr_o,
  input  logic [tmcw_pkg::CellW-1:0]  rdata_i
);

  localparam int unsigned Cells   = COLUMNS * ROWS;
  localparam int unsigned CopyEnd = Cells - COLUMNS;
  localparam int unsigned IW      = (AW > tmcw_pkg::IndexW) ? AW : tmcw_pkg::IndexW;
  localparam int unsigned ColW    = tmcw_pkg::ColW;
  localparam int unsigned RowW    = tmcw_pkg::RowW;

  tmcw_pkg::state_e state_q, state_d;
  logic [AW-1:0]                  cnt_q, cnt_d;
  logic [tmcw_pkg::ColW-1:0]      col_q, col_d;
  logic [tmcw_pkg::RowW-1:0]      row_q, row_d;
  logic [tmcw_pkg::CharW-1:0]     color_q;
  logic                           done_q, done_d;
  logic                           res_pend_q, res_pend_d;
  logic [tmcw_pkg::CellW-1:0]     cell_q, cell_d;
  logic                           rd_ok_q, rd_ok_d;

  logic [AW-1:0]                  cur_addr;
  logic [IW-1:0]                  idx_w;
  logic                           last_col, last_row;
  logic [3:0]                     tab_mod [128];
  logic [15:0]                    pos_full;

  // Column modulo tab stop, a constant table.
  for (genvar g = 0; g < 128; g++) begin : g_tab_mod
    assign tab_mod[g] = 4'(g % TAB_STOP);
  end

  // Linear address of the cursor cell.
  assign cur_addr = AW'(AW'(row_q) * AW'(COLUMNS)) + AW'(col_q);
  assign last_col = (col_q == ColW'(COLUMNS - 1));
  assign last_row = (row_q == RowW'(ROWS - 1));
  assign idx_w    = IW'(cell_index_i);

  // Next-state logic of the sequencer.
  always_comb begin
    logic nl;
    logic fin;
    nl         = 1'b0;
    fin        = 1'b0;
    state_d    = state_q;
    cnt_d      = cnt_q;
    col_d      = col_q;
    row_d      = row_q;
    done_d     = 1'b0;
    res_pend_d = res_pend_q;
    cell_d     = cell_q;
    rd_ok_d    = rd_ok_q;
    we_o       = 1'b0;
    waddr_o    = cur_addr;
    wdata_o    = {color_q, tmcw_pkg::BLANK_CHAR};
    re_o       = 1'b0;
    raddr_o    = cnt_q + AW'(COLUMNS);

    unique case (state_q)
      // Fill every cell with a blank in the clear color.
      tmcw_pkg::ST_CLEAR: begin
        we_o    = 1'b1;
        waddr_o = cnt_q;
        wdata_o = tmcw_pkg::CLEAR_CELL;
        cnt_d   = cnt_q + AW'(1);
        if (cnt_q == AW'(Cells - 1)) begin
          cnt_d      = '0;
          state_d    = tmcw_pkg::ST_IDLE;
          done_d     = res_pend_q;
          res_pend_d = 1'b0;
        end
      end

      tmcw_pkg::ST_IDLE: begin
        if (start) begin
          cell_d = '0;
          unique case (tmcw_pkg::action_e'(action_i))
            tmcw_pkg::ACT_PUT: begin
              priority if (char_code_i == tmcw_pkg::CHAR_LF) begin
                nl = 1'b1;
              end else if (char_code_i == tmcw_pkg::CHAR_CR) begin
                col_d = '0;
                fin   = 1'b1;
              end else if (char_code_i == tmcw_pkg::CHAR_TAB) begin
                state_d = tmcw_pkg::ST_TAB;
              end else if (char_code_i == tmcw_pkg::CHAR_BS) begin
                if (col_q != '0) begin
                  we_o    = 1'b1;
                  waddr_o = cur_addr - AW'(1);
                  col_d   = col_q - ColW'(1);
                end
                fin = 1'b1;
              end else if (char_code_i >= tmcw_pkg::FIRST_PRINTABLE &&
                           char_code_i < tmcw_pkg::PAST_PRINTABLE) begin
                we_o    = 1'b1;
                wdata_o = {color_q, char_code_i};
                if (last_col) begin
                  nl = 1'b1;
                end else begin
                  col_d = col_q + ColW'(1);
                  fin   = 1'b1;
                end
              end else begin
                fin = 1'b1;
              end
            end
            tmcw_pkg::ACT_READ: begin
              re_o    = 1'b1;
              raddr_o = idx_w[AW-1:0];
              rd_ok_d = ((IW+1)'(cell_index_i) < (IW+1)'(Cells));
              state_d = tmcw_pkg::ST_READ;
            end
            tmcw_pkg::ACT_CLEAR: begin
              state_d    = tmcw_pkg::ST_CLEAR;
              cnt_d      = '0;
              col_d      = '0;
              row_d      = '0;
              res_pend_d = 1'b1;
            end
            tmcw_pkg::ACT_SET: begin
              if ({1'b0, new_col_i} < (ColW+1)'(COLUMNS)) begin
                col_d = new_col_i;
              end
              if ({1'b0, new_row_i} < (RowW+1)'(ROWS)) begin
                row_d = new_row_i;
              end
              fin = 1'b1;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      // Registered read data is on the memory output now.
      tmcw_pkg::ST_READ: begin
        cell_d  = rd_ok_q ? rdata_i : '0;
        done_d  = 1'b1;
        state_d = tmcw_pkg::ST_IDLE;
      end

      // One blank per cycle until the next tab stop or the end of the row.
      tmcw_pkg::ST_TAB: begin
        we_o = 1'b1;
        if (last_col) begin
          nl = 1'b1;
        end else begin
          col_d = col_q + ColW'(1);
          if (tab_mod[col_q] == 4'(TAB_STOP - 1)) begin
            state_d = tmcw_pkg::ST_IDLE;
            fin     = 1'b1;
          end
        end
      end

      // Copy each cell one row up: read ahead, write the previous read back.
      tmcw_pkg::ST_SCROLL: begin
        if (cnt_q != AW'(CopyEnd)) begin
          re_o = 1'b1;
        end
        if (cnt_q != '0) begin
          we_o    = 1'b1;
          waddr_o = cnt_q - AW'(1);
          wdata_o = rdata_i;
        end
        cnt_d = cnt_q + AW'(1);
        if (cnt_q == AW'(CopyEnd)) begin
          cnt_d   = cnt_q;
          state_d = tmcw_pkg::ST_FILL;
        end
      end

      // Blank the new bottom row in the current color.
      tmcw_pkg::ST_FILL: begin
        we_o    = 1'b1;
        waddr_o = cnt_q;
        cnt_d   = cnt_q + AW'(1);
        if (cnt_q == AW'(Cells - 1)) begin
          cnt_d   = '0;
          state_d = tmcw_pkg::ST_IDLE;
          done_d  = 1'b1;
        end
      end

      default: begin
        state_d = tmcw_pkg::ST_IDLE;
      end
    endcase

    // Line feed, either asked for or caused by a wrap at the last column.
    if (nl) begin
      col_d = '0;
      cnt_d = '0;
      if (last_row) begin
        state_d = tmcw_pkg::ST_SCROLL;
      end else begin
        row_d   = row_q + RowW'(1);
        state_d = tmcw_pkg::ST_IDLE;
        done_d  = 1'b1;
      end
    end else if (fin) begin
      done_d = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= tmcw_pkg::ST_CLEAR;
      cnt_q      <= '0;
      col_q      <= '0;
      row_q      <= '0;
      done_q     <= 1'b0;
      res_pend_q <= 1'b0;
      color_q    <= tmcw_pkg::TEXT_COLOR_RESET;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      col_q      <= col_d;
      row_q      <= row_d;
      done_q     <= done_d;
      res_pend_q <= res_pend_d;
      if (cfg_valid_i && cfg_ready_o) begin
        color_q <= cfg_data_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cell_q  <= cell_d;
    rd_ok_q <= rd_ok_d;
  end

  // Result and handshake outputs.
  assign pos_full          = 16'(row_q) * 16'(COLUMNS) + 16'(col_q);
  assign cursor_position_o = pos_full[tmcw_pkg::IndexW-1:0];
  assign cursor_col_o      = col_q;
  assign cursor_row_o      = row_q;
  assign cell_value_o      = cell_q;
  assign done_o            = done_q;
  assign busy              = (state_q != tmcw_pkg::ST_IDLE);
  assign cfg_ready_o       = 1'b1;

endmodule

// ----- rtl/text_mode_console_writer.sv -----
// Top level of the text mode console writer.
// Depends on tmcw_pkg, tmcw_seq and tmcw_screen.
//
// Usage:
// - Command channel: a transaction is taken at a clock edge with start high and busy low.
//   action selects put character, read cell, clear screen or set cursor.
// - Result channel: done_o is high for one cycle with cell_value_o and the cursor ports;
//   the receiver cannot stall, and every command gives exactly one result.
// - Configuration channel: cfg_valid_i/cfg_ready_o write the text color; ready is always
//   high, and writes are expected only while no command is in flight.
// Steps from acceptance to done_o:
// - Set cursor, carriage return, backspace, printable and ignored characters: next cycle.
// - Read cell: the registered memory read, then ST_READ, which latches the cell value.
// - Tab: one blank written per cycle up to the next tab stop, at most TAB_STOP blanks.
// - Line feed or wrap on the bottom row: the scroll copies each cell one row up, then
//   the row fill blanks the bottom row (after a tab, these follow its blanks).
// - Clear screen: every cell is blanked, one cell written per cycle.
// busy is low again in the cycle done_o is shown, so a new command may be taken then.
// Reset: the cursor goes to 0,0, the color to 15, and a clearing pass blanks the screen
// while busy is high; it gives no result.
module text_mode_console_writer #(
  parameter int unsigned COLUMNS  = tmcw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS     = tmcw_pkg::ROWS_DEF,
  parameter int unsigned TAB_STOP = tmcw_pkg::TAB_STOP_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  action_i,
  input  logic [tmcw_pkg::CharW-1:0]  char_code_i,
  input  logic [tmcw_pkg::IndexW-1:0] cell_index_i,
  input  logic [tmcw_pkg::ColW-1:0]   new_col_i,
  input  logic [tmcw_pkg::RowW-1:0]   new_row_i,
  output logic                        done_o,
  output logic [tmcw_pkg::CellW-1:0]  cell_value_o,
  output logic [tmcw_pkg::IndexW-1:0] cursor_position_o,
  output logic [tmcw_pkg::ColW-1:0]   cursor_col_o,
  output logic [tmcw_pkg::RowW-1:0]   cursor_row_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [tmcw_pkg::CharW-1:0]  cfg_data_i
);

  localparam int unsigned Cells = COLUMNS * ROWS;
  localparam int unsigned AW    = $clog2(Cells);

  logic                       we;
  logic [AW-1:0]              waddr;
  logic [tmcw_pkg::CellW-1:0] wdata;
  logic                       re;
  logic [AW-1:0]              raddr;
  logic [tmcw_pkg::CellW-1:0] rdata;

  // Sequencer.
  tmcw_seq #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP),
    .AW       (AW)
  ) u_seq (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .action_i          (action_i),
    .char_code_i       (char_code_i),
    .cell_index_i      (cell_index_i),
    .new_col_i         (new_col_i),
    .new_row_i         (new_row_i),
    .done_o            (done_o),
    .cell_value_o      (cell_value_o),
    .cursor_position_o (cursor_position_o),
    .cursor_col_o      (cursor_col_o),
    .cursor_row_o      (cursor_row_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .we_o              (we),
    .waddr_o           (waddr),
    .wdata_o           (wdata),
    .re_o              (re),
    .raddr_o           (raddr),
    .rdata_i           (rdata)
  );

  // Screen memory.
  tmcw_screen #(
    .DEPTH (Cells),
    .AW    (AW)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

endmodule

// ----- rtl/tmcw_checker.sv -----
// Port-level checker of the text mode console writer, bound to the top level.
// Depends on tmcw_pkg and text_mode_console_writer_assert.svh.
`include "text_mode_console_writer_assert.svh"

module tmcw_checker #(
  parameter int unsigned COLUMNS = tmcw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tmcw_pkg::ROWS_DEF
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic [1:0]                  action_i,
  input logic [tmcw_pkg::IndexW-1:0] cell_index_i,
  input logic [tmcw_pkg::ColW-1:0]   new_col_i,
  input logic [tmcw_pkg::RowW-1:0]   new_row_i,
  input logic                        done_o,
  input logic [tmcw_pkg::CellW-1:0]  cell_value_o,
  input logic [tmcw_pkg::IndexW-1:0] cursor_position_o,
  input logic [tmcw_pkg::ColW-1:0]   cursor_col_o,
  input logic [tmcw_pkg::RowW-1:0]   cursor_row_o
);

  logic [15:0] pos_full;
  logic        set_ok;
  logic        read_oor;

  assign pos_full = 16'(cursor_row_o) * 16'(COLUMNS) + 16'(cursor_col_o);
  assign set_ok   = start && !busy && (action_i == tmcw_pkg::ACT_SET) &&
                    (8'(new_col_i) < 8'(COLUMNS)) && (6'(new_row_i) < 6'(ROWS));
  assign read_oor = start && !busy && (action_i == tmcw_pkg::ACT_READ) &&
                    (13'(cell_index_i) >= 13'(COLUMNS * ROWS));

  // A result always ends the transaction: the block is free in that cycle.
  `TMCW_ASSERT_NOW(a_done_not_busy, done_o, !busy, "result shown while busy")

  // The cursor stays on the screen and the linear position matches it.
  `TMCW_ASSERT_NOW(a_cursor_pos, done_o,
    (8'(cursor_col_o) < 8'(COLUMNS)) && (6'(cursor_row_o) < 6'(ROWS)) &&
    (cursor_position_o == pos_full[tmcw_pkg::IndexW-1:0]), "cursor out of place")

  // An in-range set cursor takes effect and reports in the next cycle.
  `TMCW_ASSERT_NEXT(a_set_cursor, set_ok,
    done_o && (cursor_col_o == $past(new_col_i)) && (cursor_row_o == $past(new_row_i)),
    "set cursor not applied")

  // A read beyond the screen returns zero in its result, after the registered read and ST_READ.
  `TMCW_ASSERT_DLY2(a_read_oor, read_oor, done_o && (cell_value_o == '0),
    "out of range read not zero")

endmodule

bind text_mode_console_writer tmcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tmcw_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start             (start),
  .busy              (busy),
  .action_i          (action_i),
  .cell_index_i      (cell_index_i),
  .new_col_i         (new_col_i),
  .new_row_i         (new_row_i),
  .done_o            (done_o),
  .cell_value_o      (cell_value_o),
  .cursor_position_o (cursor_position_o),
  .cursor_col_o      (cursor_col_o),
  .cursor_row_o      (cursor_row_o)
);
